// ===== hw/rtl/csw_pkg.sv =====
package csw_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned AddrW = 4;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    RegMinX = 2'd0,
    RegMaxX = 2'd1,
    RegMinY = 2'd2,
    RegMaxY = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic   ok;
    coord_t p0x;
    coord_t p0y;
    coord_t p1x;
    coord_t p1y;
  } seg_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } window_t;

endpackage

// ===== hw/rtl/clip_segment_to_window.sv =====
// Segment clipper against a four-register window, min x / max x / min y / max y in turn.
// Throughput: one segment per cycle while busy_o is low; each edge stage is a
// 35-deep pipeline whose length is set by the one-bit-per-stage restoring divider.
// Reset: window registers clear to 0, pipeline empties; results cannot be stalled.
module clip_segment_to_window import csw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  coord_t           first_x_i,
  input  coord_t           first_y_i,
  input  coord_t           second_x_i,
  input  coord_t           second_y_i,
  output logic             done_o,
  output logic             visible_o,
  output coord_t           out_first_x_o,
  output coord_t           out_first_y_o,
  output coord_t           out_second_x_o,
  output coord_t           out_second_y_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  window_t  win_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegMinX: win_q.min_x <= pwdata;
        RegMaxX: win_q.max_x <= pwdata;
        RegMinY: win_q.min_y <= pwdata;
        RegMaxY: win_q.max_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMinX: prdata = win_q.min_x;
      RegMaxX: prdata = win_q.max_x;
      RegMinY: prdata = win_q.min_y;
      RegMaxY: prdata = win_q.max_y;
      default: prdata = '0;
    endcase
  end

  logic full, front_vld, q_vld;
  seg_t front_seg, q_seg;

  csw_front u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .full_i     (full),
    .first_x_i,
    .first_y_i,
    .second_x_i,
    .second_y_i,
    .busy_o,
    .vld_o      (front_vld),
    .seg_o      (front_seg)
  );

  csw_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (front_vld),
    .data_i (front_seg),
    .full_o (full),
    .vld_o  (q_vld),
    .data_o (q_seg)
  );

  logic   evld [5];
  seg_t   eseg [5];
  coord_t bound [4];

  assign evld[0]  = q_vld;
  assign eseg[0]  = q_seg;
  assign bound[0] = win_q.min_x;
  assign bound[1] = win_q.max_x;
  assign bound[2] = win_q.min_y;
  assign bound[3] = win_q.max_y;

  for (genvar e = 0; e < 4; e++) begin : g_edge
    csw_edge u_edge (
      .clk_i,
      .rst_ni,
      .axis_i   (e >= 2),
      .is_max_i ((e % 2) == 1),
      .bound_i  (bound[e]),
      .vld_i    (evld[e]),
      .seg_i    (eseg[e]),
      .vld_o    (evld[e+1]),
      .seg_o    (eseg[e+1])
    );
  end

  // drop coordinates of a rejected segment
  assign done_o         = evld[4];
  assign visible_o      = eseg[4].ok;
  assign out_first_x_o  = eseg[4].ok ? eseg[4].p0x : '0;
  assign out_first_y_o  = eseg[4].ok ? eseg[4].p0y : '0;
  assign out_second_x_o = eseg[4].ok ? eseg[4].p1x : '0;
  assign out_second_y_o = eseg[4].ok ? eseg[4].p1y : '0;

endmodule

// ===== hw/rtl/csw_front.sv =====
module csw_front import csw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  logic   full_i,
  input  coord_t first_x_i,
  input  coord_t first_y_i,
  input  coord_t second_x_i,
  input  coord_t second_y_i,
  output logic   busy_o,
  output logic   vld_o,
  output seg_t   seg_o
);

  logic accept;
  logic vld_q;
  seg_t seg_q;

  assign busy_o = full_i;
  assign accept = start_i && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept;
    end
  end

  // every segment enters as a candidate; the edge stages decide
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_q <= '{ok: 1'b1, p0x: first_x_i, p0y: first_y_i,
                 p1x: second_x_i, p1y: second_y_i};
    end
  end

  assign vld_o = vld_q;
  assign seg_o = seg_q;

endmodule

// ===== hw/rtl/csw_queue.sv =====
module csw_queue import csw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  seg_t data_i,
  output logic full_o,
  output logic vld_o,
  output seg_t data_o
);

  seg_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  // the edge pipeline never stalls, so drain every cycle
  assign pop    = (cnt_q != 2'd0);
  assign full_o = (cnt_q == 2'd2);
  assign vld_o  = pop;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/csw_edge.sv =====
module csw_edge import csw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   axis_i,
  input  logic   is_max_i,
  input  coord_t bound_i,
  input  logic   vld_i,
  input  seg_t   seg_i,
  output logic   vld_o,
  output seg_t   seg_o
);

  typedef struct packed {
    seg_t              seg;
    logic              clip;
    logic              k;
    logic              neg;
    coord_t            a1;
    logic [CoordW:0]   mda;
    logic [CoordW:0]   mdt;
    logic [CoordW:0]   mdb;
  } cls_t;

  typedef struct packed {
    seg_t              seg;
    logic              clip;
    logic              k;
    logic              neg;
    coord_t            a1;
    logic [CoordW:0]   d;
    logic [CoordW:0]   rem;
    logic [CoordW-1:0] low;
    logic [CoordW-1:0] quo;
  } div_t;

  // classify
  coord_t                b1, b2, a1, a2;
  logic                  in0, in1, clip;
  logic signed [CoordW:0] da, dt, db;
  cls_t                  cls_d, cls_q;
  logic                  cls_vld_q;

  always_comb begin
    b1   = axis_i ? seg_i.p0y : seg_i.p0x;
    b2   = axis_i ? seg_i.p1y : seg_i.p1x;
    a1   = axis_i ? seg_i.p0x : seg_i.p0y;
    a2   = axis_i ? seg_i.p1x : seg_i.p1y;
    // on the edge counts as outside
    in0  = is_max_i ? (b1 < bound_i) : (b1 > bound_i);
    in1  = is_max_i ? (b2 < bound_i) : (b2 > bound_i);
    clip = seg_i.ok && (in0 != in1);
    da   = $signed({a2[CoordW-1], a2}) - $signed({a1[CoordW-1], a1});
    dt   = $signed({bound_i[CoordW-1], bound_i}) - $signed({b1[CoordW-1], b1});
    db   = $signed({b2[CoordW-1], b2}) - $signed({b1[CoordW-1], b1});
    cls_d.seg    = seg_i;
    cls_d.seg.ok = seg_i.ok && (clip || in0);
    cls_d.clip   = clip;
    cls_d.k      = in0;
    cls_d.neg    = da[CoordW] ^ dt[CoordW] ^ db[CoordW];
    cls_d.a1     = a1;
    cls_d.mda    = da[CoordW] ? -da : da;
    cls_d.mdt    = dt[CoordW] ? -dt : dt;
    cls_d.mdb    = db[CoordW] ? -db : db;
  end

  // multiply, then one quotient bit per stage; for a crossing segment the quotient never exceeds |da|
  div_t                  div_q [CoordW+1];
  logic                  dvld_q [CoordW+1];
  logic [2*CoordW+1:0]   prod;

  assign prod = cls_q.mda * cls_q.mdt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_vld_q <= 1'b0;
      dvld_q[0] <= 1'b0;
    end else begin
      cls_vld_q <= vld_i;
      dvld_q[0] <= cls_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q         <= cls_d;
    div_q[0].seg  <= cls_q.seg;
    div_q[0].clip <= cls_q.clip;
    div_q[0].k    <= cls_q.k;
    div_q[0].neg  <= cls_q.neg;
    div_q[0].a1   <= cls_q.a1;
    div_q[0].d    <= cls_q.mdb;
    div_q[0].rem  <= prod[2*CoordW:CoordW];
    div_q[0].low  <= prod[CoordW-1:0];
    div_q[0].quo  <= '0;
  end

  for (genvar s = 0; s < CoordW; s++) begin : g_div
    localparam int unsigned Bit = CoordW - 1 - s;
    logic [CoordW+1:0] shifted, trial;
    div_t              step_d;

    always_comb begin
      shifted = {div_q[s].rem, div_q[s].low[Bit]};
      trial   = shifted - {1'b0, div_q[s].d};
      step_d  = div_q[s];
      if (!trial[CoordW+1]) begin
        step_d.rem      = trial[CoordW:0];
        step_d.quo[Bit] = 1'b1;
      end else begin
        step_d.rem = shifted[CoordW:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[s+1] <= 1'b0;
      end else begin
        dvld_q[s+1] <= dvld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[s+1] <= step_d;
    end
  end

  // move the outer endpoint onto the edge
  div_t                     fin;
  logic signed [CoordW+1:0] sum;
  coord_t                   t;
  seg_t                     out_d, out_q;
  logic                     out_vld_q;

  always_comb begin
    fin = div_q[CoordW];
    if (fin.neg) begin
      sum = $signed({{2{fin.a1[CoordW-1]}}, fin.a1}) - $signed({2'b00, fin.quo});
    end else begin
      sum = $signed({{2{fin.a1[CoordW-1]}}, fin.a1}) + $signed({2'b00, fin.quo});
    end
    if (sum[CoordW+1] && !(sum[CoordW] && sum[CoordW-1])) begin
      t = {1'b1, {(CoordW-1){1'b0}}};
    end else if (!sum[CoordW+1] && (sum[CoordW] || sum[CoordW-1])) begin
      t = {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      t = sum[CoordW-1:0];
    end
    out_d = fin.seg;
    if (fin.clip) begin
      if (fin.k) begin
        if (axis_i) begin
          out_d.p1y = bound_i;
          out_d.p1x = t;
        end else begin
          out_d.p1x = bound_i;
          out_d.p1y = t;
        end
      end else begin
        if (axis_i) begin
          out_d.p0y = bound_i;
          out_d.p0x = t;
        end else begin
          out_d.p0x = bound_i;
          out_d.p0y = t;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dvld_q[CoordW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign vld_o = out_vld_q;
  assign seg_o = out_q;

endmodule

// ===== tb/seg_clip_checker.sv =====
`timescale 1ns / 1ps

module seg_clip_checker import csw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  coord_t           first_x_i,
  input  coord_t           first_y_i,
  input  coord_t           second_x_i,
  input  coord_t           second_y_i,
  input  logic             done_i,
  input  logic             visible_i,
  input  coord_t           out_first_x_i,
  input  coord_t           out_first_y_i,
  input  coord_t           out_second_x_i,
  input  coord_t           out_second_y_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam logic [127:0] QuotLimit = 128'h1 << 52;
  localparam longint CoordMax = (64'sd1 <<< (CoordW - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;

  window_t win;
  seg_t    clipped_q[$];

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // a1 + (a2 - a1) * (m - b1) / (b2 - b1), truncated toward zero, saturated
  function automatic longint edge_cross(longint a1, longint a2, longint b1, longint b2,
                                        longint m);
    longint       da, dt, db, r;
    logic         neg;
    logic [127:0] prod, quot;
    da = a2 - a1;
    dt = m - b1;
    db = b2 - b1;
    if (da == 0 || dt == 0 || db == 0) return a1;
    neg  = ((da < 0) != (dt < 0)) != (db < 0);
    prod = 128'(magnitude(da)) * 128'(magnitude(dt));
    quot = prod / 128'(magnitude(db));
    if (quot > QuotLimit) quot = QuotLimit;
    r = neg ? a1 - longint'(quot[63:0]) : a1 + longint'(quot[63:0]);
    if (r > CoordMax) r = CoordMax;
    if (r < CoordMin) r = CoordMin;
    return r;
  endfunction

  function automatic seg_t clip_segment(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                        window_t w);
    longint pt[2][2];
    longint m, t;
    int     axis, other, k;
    logic   is_max, in0, in1, ok;
    seg_t   s;
    pt[0][0] = x0;
    pt[0][1] = y0;
    pt[1][0] = x1;
    pt[1][1] = y1;
    ok = 1'b1;
    for (int e = 0; e < 4 && ok; e++) begin
      axis   = e / 2;
      other  = 1 - axis;
      is_max = e[0];
      case (e)
        0: m = w.min_x;
        1: m = w.max_x;
        2: m = w.min_y;
        default: m = w.max_y;
      endcase
      in0 = is_max ? (pt[0][axis] < m) : (pt[0][axis] > m);
      in1 = is_max ? (pt[1][axis] < m) : (pt[1][axis] > m);
      if (in0 != in1) begin
        t = edge_cross(pt[0][other], pt[1][other], pt[0][axis], pt[1][axis], m);
        k = in0 ? 1 : 0;
        pt[k][axis]  = m;
        pt[k][other] = t;
      end else begin
        ok = in0;
      end
    end
    s = '0;
    if (ok) begin
      s.ok  = 1'b1;
      s.p0x = coord_t'(pt[0][0]);
      s.p0y = coord_t'(pt[0][1]);
      s.p1x = coord_t'(pt[1][0]);
      s.p1y = coord_t'(pt[1][1]);
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    seg_t want;
    if (!rst_ni) begin
      win <= '0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          RegMinX: win.min_x <= pwdata_i;
          RegMaxX: win.max_x <= pwdata_i;
          RegMinY: win.min_y <= pwdata_i;
          RegMaxY: win.max_y <= pwdata_i;
          default: ;
        endcase
      end
      if (done_i) begin
        if (clipped_q.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding", $realtime);
          fail_count_o++;
        end else begin
          want = clipped_q.pop_front();
          if (visible_i !== want.ok) report_mismatch("visible", visible_i, want.ok);
          if (out_first_x_i !== want.p0x) report_mismatch("out_first_x", out_first_x_i, want.p0x);
          if (out_first_y_i !== want.p0y) report_mismatch("out_first_y", out_first_y_i, want.p0y);
          if (out_second_x_i !== want.p1x)
            report_mismatch("out_second_x", out_second_x_i, want.p1x);
          if (out_second_y_i !== want.p1y)
            report_mismatch("out_second_y", out_second_y_i, want.p1y);
        end
      end
      if (start_i && !busy_i)
        clipped_q.push_back(clip_segment(first_x_i, first_y_i, second_x_i, second_y_i, win));
      pending_o = clipped_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import csw_pkg::*;

  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -64'sd2147483648;
  localparam longint One = 64'sd65536;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  coord_t           first_x_i, first_y_i, second_x_i, second_y_i;
  logic             done_o;
  logic             visible_o;
  coord_t           out_first_x_o, out_first_y_o, out_second_x_o, out_second_y_o;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata, prdata;
  int               fail_count, pending;
  logic             allow_idle;
  window_t          cur_win;

  clip_segment_to_window u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i,
    .done_o, .visible_o,
    .out_first_x_o, .out_first_y_o, .out_second_x_o, .out_second_y_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  seg_clip_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .first_x_i, .first_y_i, .second_x_i, .second_y_i,
    .done_i(done_o), .visible_i(visible_o),
    .out_first_x_i(out_first_x_o), .out_first_y_i(out_first_y_o),
    .out_second_x_i(out_second_x_o), .out_second_y_i(out_second_y_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, coord_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_win = cur_win;
    case (idx)
      RegMinX: cur_win.min_x = value;
      RegMaxX: cur_win.max_x = value;
      RegMinY: cur_win.min_y = value;
      default: cur_win.max_y = value;
    endcase
  endtask

  task automatic set_window(longint x0, longint x1, longint y0, longint y1);
    // stop new transfers, drain outstanding ones, then wait out the pipeline
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if ($urandom_range(0, 1)) begin
      write_reg(RegMaxY, coord_t'(y1));
      write_reg(RegMinX, coord_t'(x0));
      write_reg(RegMinY, coord_t'(y0));
      write_reg(RegMaxX, coord_t'(x1));
    end else begin
      write_reg(RegMinX, coord_t'(x0));
      write_reg(RegMaxX, coord_t'(x1));
      write_reg(RegMinY, coord_t'(y0));
      write_reg(RegMaxY, coord_t'(y1));
    end
  endtask

  task automatic send_segment(longint x0, longint y0, longint x1, longint y1);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    first_x_i  <= coord_t'(x0);
    first_y_i  <= coord_t'(y0);
    second_x_i <= coord_t'(x1);
    second_y_i <= coord_t'(y1);
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic longint pick_coord(longint lo, longint hi);
    longint a, b, span, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a + 1;
    case ($urandom_range(0, 9))
      0, 1: v = longint'(signed'($urandom));
      2: begin
        case ($urandom_range(0, 3))
          0: v = CoordMin;
          1: v = CoordMax;
          2: v = 0;
          default: v = -1;
        endcase
      end
      3: v = $urandom_range(0, 1) ? lo : hi;
      default: v = a - span + longint'({$urandom, $urandom} % 64'(3 * span));
    endcase
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return v;
  endfunction

  task automatic random_segments(int count);
    for (int i = 0; i < count; i++)
      send_segment(pick_coord(cur_win.min_x, cur_win.max_x),
                   pick_coord(cur_win.min_y, cur_win.max_y),
                   pick_coord(cur_win.min_x, cur_win.max_x),
                   pick_coord(cur_win.min_y, cur_win.max_y));
  endtask

  task automatic random_window();
    longint a, b, c, d;
    a = longint'(signed'($urandom)) >>> $urandom_range(0, 16);
    b = a + longint'($urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 24));
    c = longint'(signed'($urandom)) >>> $urandom_range(0, 16);
    d = c + longint'($urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 24));
    if (b > CoordMax) b = CoordMax;
    if (d > CoordMax) d = CoordMax;
    set_window(a, b, c, d);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    first_x_i  = '0;
    first_y_i  = '0;
    second_x_i = '0;
    second_y_i = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    allow_idle = 1'b1;
    cur_win    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero window after reset
    send_segment(-One, -One, One, One);
    random_segments(80);

    set_window(-10 * One, 10 * One, -5 * One, 5 * One);
    send_segment(-20 * One, 0, 20 * One, 0);           // crosses the min x and max x bounds
    send_segment(0, -20 * One, 0, 20 * One);           // crosses the min y and max y bounds
    send_segment(-One, -One, One, One);                // fully inside
    send_segment(-20 * One, One, -15 * One, 2 * One);  // both left of window
    send_segment(15 * One, One, 20 * One, 2 * One);    // both right
    send_segment(0, -9 * One, One, -8 * One);          // both below
    send_segment(0, 8 * One, One, 9 * One);            // both above
    send_segment(-10 * One, 0, 0, 0);                  // endpoint on left edge
    send_segment(-10 * One, -One, -10 * One, One);     // lies on left edge
    send_segment(10 * One, 0, 5 * One, One);           // endpoint on right edge
    send_segment(0, 5 * One, 0, -5 * One);             // endpoints on the max y and min y bounds
    send_segment(CoordMin, CoordMin, CoordMax, CoordMax);
    send_segment(CoordMax, CoordMin, CoordMin, CoordMax);
    send_segment(CoordMin, 0, CoordMax, 0);
    send_segment(0, CoordMax, 0, CoordMin);
    send_segment(One, One, One, One);                  // single point
    send_segment(-30 * One, -7 * One, 30 * One, 9 * One);
    send_segment(-11 * One, 4 * One, 12 * One, -6 * One);
    send_segment(3, -7, -30 * One + 1, 17 * One - 3);
    random_segments(160);

    set_window(CoordMin, CoordMax, CoordMin, CoordMax);
    send_segment(CoordMin, CoordMin, CoordMax, CoordMax);
    send_segment(CoordMax, CoordMax, 0, 0);
    random_segments(160);

    set_window(5 * One, -5 * One, 3 * One, -3 * One);  // inverted
    random_segments(120);

    set_window(0, 1, 0, 1);                            // one-lsb wide
    random_segments(120);

    set_window(CoordMax, CoordMax, CoordMin, CoordMin);
    random_segments(60);

    for (int p = 0; p < 5; p++) begin
      random_window();
      random_segments(140);
    end

    allow_idle = 1'b0;
    random_window();
    random_segments(150);
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
